// ----- rtl/btqrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package btqrd_pkg;

   localparam int DEPTH       = 64;
   localparam int HANDLE_BITS = 16;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int POS_W       = $clog2(DEPTH);
   localparam int LFSR_W      = 32;
   localparam int LIMIT_W     = 7;
   localparam int STEP_W      = $clog2(LFSR_W);

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

   // Request codes; code 3 is unused and is refused.
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_DROP = 2'd2;

   localparam logic [1:0] KIND_PUSHED  = 2'd0;
   localparam logic [1:0] KIND_POPPED  = 2'd1;
   localparam logic [1:0] KIND_DROPPED = 2'd2;
   localparam logic [1:0] KIND_REFUSED = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic CSR_LIMIT = 1'b0;
   localparam logic CSR_SEED  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic                start;
      logic [LFSR_W-1:0]   dividend;
      logic [COUNT_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic                done;
      logic [COUNT_W-1:0]  remainder;
   } mod_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/btqrd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btqrd_cell
   import btqrd_pkg::*;
(
   input  wire logic                   clock,
   input  wire cell_ctl_type           ctl,
   input  wire logic [HANDLE_BITS-1:0] load_data,
   input  wire logic [HANDLE_BITS-1:0] next_data,
   output logic      [HANDLE_BITS-1:0] data
);

   logic [HANDLE_BITS-1:0] data_ff;

   // A shift pulls the neighbor's item in and closes a gap below it.
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= next_data;
      end else if (ctl.load) begin
         data_ff <= load_data;
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- rtl/btqrd_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btqrd_mod
   import btqrd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output mod_rsp_type      rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [LFSR_W-1:0]   dvd_ff, dvd_in;
   logic [COUNT_W:0]    shifted;

   // Restoring division, one dividend bit per cycle, MSB first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      shifted = {rem_ff, dvd_ff[LFSR_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(LFSR_W - 1);
         rem_in  = '0;
         div_in  = req.divisor;
         dvd_in  = req.dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = COUNT_W'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = COUNT_W'(shifted);
         end
         dvd_in  = {dvd_ff[LFSR_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      dvd_ff  <= dvd_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/bounded_task_queue_random_drop_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounded task queue with random drop on overload.
// An item is taken when start is high and busy is low. req_type selects push
// (req_task_handle goes to the tail), pop (the head comes out) or drop, which
// removes (occupancy/10)*3 items, at least one, each at a position given by a
// 32-bit Galois LFSR modulo the current occupancy.
// Every result is shown for one cycle with rsp_valid high and carries the
// kind, the handle, the status and the occupancy after it; rsp_last marks the
// final result of an item. Refused requests give one refused result.
// Push, pop and refusals: the result appears in the cycle after the item is
// taken, and a new item can be taken every cycle.
// Drop: each removal waits for the bit-serial modulo unit that divides the
// LFSR word by the occupancy one bit per cycle; busy stays high until the last
// removal is shown.
// The items sit in a row of cells; a removal shifts every cell above the gap
// down by one at the same edge. The receiver cannot stall, so results are
// never held. Reset empties the queue, sets the limit to its maximum and the
// LFSR to 1; a seed write loads the LFSR at once, a zero seed as 1.
module bounded_task_queue_random_drop_core
   import btqrd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_type,
   input  wire logic [HANDLE_BITS-1:0] req_task_handle,
   output logic                        rsp_valid,
   output logic      [1:0]             rsp_result_kind,
   output logic      [HANDLE_BITS-1:0] rsp_task_out,
   output logic      [1:0]             rsp_queue_status,
   output logic      [COUNT_W-1:0]     rsp_occupancy,
   output logic                        rsp_last,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [LFSR_W-1:0]      csr_wdata
);

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     left_ff, left_in;
   logic [LFSR_W-1:0]      lfsr_ff, lfsr_in;
   logic [LIMIT_W-1:0]     limit_ff;

   logic                   valid_ff, valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic [HANDLE_BITS-1:0] task_ff, task_in;
   logic [1:0]             stat_ff, stat_in;
   logic                   last_ff, last_in;

   logic [COUNT_W-1:0]     limit_eff;
   logic                   accept;
   logic                   take_en;
   logic                   load_en;
   logic [POS_W-1:0]       take_pos;
   logic [HANDLE_BITS-1:0] take_data;
   logic [LFSR_W-1:0]      lfsr_next;
   logic [COUNT_W+7:0]     tenth_prod;
   logic [COUNT_W-1:0]     drop_n;
   mod_req_type            mreq;
   mod_rsp_type            mrsp;

   logic [HANDLE_BITS-1:0] cell_data [DEPTH];
   cell_ctl_type           cell_ctl  [DEPTH];

   function automatic logic [1:0] status_of(input logic [COUNT_W-1:0] cnt,
                                            input logic [COUNT_W-1:0] lim);
      if (cnt == '0) begin
         return STAT_EMPTY;
      end else if (cnt >= lim) begin
         return STAT_FULL;
      end
      return STAT_OK;
   endfunction

   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = COUNT_W'(1);
      end else if (32'(limit_ff) > 32'(DEPTH)) begin
         limit_eff = COUNT_W'(DEPTH);
      end else begin
         limit_eff = COUNT_W'(limit_ff);
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);

   // count/10 as a reciprocal multiply; exact for every count the 7-bit counter holds (up to 127).
   assign tenth_prod = (COUNT_W+8)'(count_ff) * (COUNT_W+8)'(205);
   always_comb begin
      drop_n = COUNT_W'(tenth_prod >> 11) * COUNT_W'(3);
      if (drop_n == '0) begin
         drop_n = COUNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_DROP && count_ff != '0) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (mrsp.done && left_ff == COUNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      left_in       = left_ff;
      lfsr_in       = lfsr_ff;
      valid_in      = 1'b0;
      kind_in       = KIND_REFUSED;
      task_in       = '0;
      stat_in       = status_of(count_ff, limit_eff);
      last_in       = 1'b1;
      take_en       = 1'b0;
      load_en       = 1'b0;
      take_pos      = '0;
      mreq.start    = 1'b0;
      mreq.dividend = lfsr_next;
      mreq.divisor  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in = 1'b1;
               case (req_type)
                  REQ_PUSH: begin
                     if (count_ff < limit_eff && count_ff != COUNT_W'(DEPTH)) begin
                        load_en  = 1'b1;
                        count_in = count_ff + 1'b1;
                        kind_in  = KIND_PUSHED;
                     end
                  end
                  REQ_POP: begin
                     if (count_ff != '0) begin
                        take_en  = 1'b1;
                        count_in = count_ff - 1'b1;
                        kind_in  = KIND_POPPED;
                        task_in  = take_data;
                     end
                  end
                  REQ_DROP: begin
                     if (count_ff != '0) begin
                        // The first removal steps the LFSR and starts the divide.
                        valid_in   = 1'b0;
                        left_in    = drop_n;
                        lfsr_in    = lfsr_next;
                        mreq.start = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               stat_in = status_of(count_in, limit_eff);
            end
         end
         ST_DIVIDE: begin
            if (mrsp.done) begin
               take_pos = mrsp.remainder[POS_W-1:0];
               take_en  = 1'b1;
               count_in = count_ff - 1'b1;
               left_in  = left_ff - 1'b1;
               valid_in = 1'b1;
               kind_in  = KIND_DROPPED;
               task_in  = take_data;
               stat_in  = status_of(count_in, limit_eff);
               last_in  = (left_ff == COUNT_W'(1));
               if (left_ff != COUNT_W'(1)) begin
                  lfsr_in      = lfsr_next;
                  mreq.start   = 1'b1;
                  mreq.divisor = count_in;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign take_data = cell_data[take_pos];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [HANDLE_BITS-1:0] next_data;

      if (i == DEPTH - 1) begin : g_top
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      assign cell_ctl[i].shift = take_en && (POS_W'(i) >= take_pos);
      assign cell_ctl[i].load  = load_en && (count_ff == COUNT_W'(i));

      btqrd_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .load_data (req_task_handle),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   btqrd_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         lfsr_ff  <= LFSR_W'(1);
         limit_ff <= LIMIT_W'(64);
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (csr_we && csr_index == CSR_SEED) begin
            lfsr_ff <= (csr_wdata == '0) ? LFSR_W'(1) : csr_wdata;
         end else begin
            lfsr_ff <= lfsr_in;
         end
         if (csr_we && csr_index == CSR_LIMIT) begin
            limit_ff <= csr_wdata[LIMIT_W-1:0];
         end
      end
      left_ff <= left_in;
      kind_ff <= kind_in;
      task_ff <= task_in;
      stat_ff <= stat_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_task_out     = task_ff;
   assign rsp_queue_status = stat_ff;
   assign rsp_occupancy    = count_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// ----- bench/bounded_task_queue_random_drop_core_tb.sv -----
`timescale 1ns / 1ps

module bounded_task_queue_random_drop_core_tb;
   import btqrd_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 150;
   localparam int         QUIET_LIMIT  = 3000;
   localparam int         DRAIN_SETTLE = 2;
   localparam int         END_SETTLE   = 40;

   typedef struct packed {
      logic [1:0]             kind;
      logic [HANDLE_BITS-1:0] handle;
      logic [1:0]             status;
      logic [COUNT_W-1:0]     occupancy;
      logic                   last;
   } result_type;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_LIMIT,
      ROW_SEED
   } plan_op_type;

   typedef struct packed {
      plan_op_type       op;
      logic [1:0]        req;
      logic [LFSR_W-1:0] data;
      logic              typed;
      result_type        want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_type = REQ_PUSH;
   logic [HANDLE_BITS-1:0] req_task_handle = '0;
   logic                   rsp_valid;
   logic [1:0]             rsp_result_kind;
   logic [HANDLE_BITS-1:0] rsp_task_out;
   logic [1:0]             rsp_queue_status;
   logic [COUNT_W-1:0]     rsp_occupancy;
   logic                   rsp_last;
   logic                   csr_we = 1'b0;
   logic                   csr_index = CSR_LIMIT;
   logic [LFSR_W-1:0]      csr_wdata = '0;

   // Shadow copy of the queue, the registers and the LFSR.
   logic [HANDLE_BITS-1:0] model_tasks[$];
   logic [LIMIT_W-1:0]     limit_reg = 7'd64;
   logic [LFSR_W-1:0]      lfsr_word = 32'd1;
   result_type             pending_results[$];

   plan_row_type plan[$];
   result_type   oldest;
   bit        gaps_on = 1'b1;
   int        errors = 0;
   int        items_sent = 0;
   int        results_seen = 0;
   int        dropped_handles = 0;
   int        longest_burst = 0;
   int        csr_writes = 0;
   int        quiet_cycles = 0;

   always #5 clock = ~clock;

   bounded_task_queue_random_drop_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_task_handle  (req_task_handle),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_task_out     (rsp_task_out),
      .rsp_queue_status (rsp_queue_status),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic int effective_limit();
      if (limit_reg == 0) return 1;
      if (limit_reg > DEPTH) return DEPTH;
      return int'(limit_reg);
   endfunction

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [HANDLE_BITS-1:0] handle,
                                              input logic last);
      result_type r;
      int         n;
      n = model_tasks.size();
      r.kind      = kind;
      r.handle    = handle;
      r.occupancy = COUNT_W'(n);
      if (n == 0) r.status = STAT_EMPTY;
      else if (n >= effective_limit()) r.status = STAT_FULL;
      else r.status = STAT_OK;
      r.last = last;
      return r;
   endfunction

   // Updates the shadow queue for one accepted item and queues its results.
   function automatic void apply_request(input logic [1:0] req,
                                         input logic [HANDLE_BITS-1:0] handle,
                                         input logic typed, input result_type want);
      result_type             fresh[$];
      int                     n;
      int                     k;
      int                     pos;
      logic [HANDLE_BITS-1:0] v;
      case (req)
         REQ_PUSH: begin
            if (model_tasks.size() >= effective_limit() || model_tasks.size() >= DEPTH) begin
               fresh.push_back(make_result(KIND_REFUSED, '0, 1'b1));
            end else begin
               model_tasks.push_back(handle);
               fresh.push_back(make_result(KIND_PUSHED, '0, 1'b1));
            end
         end
         REQ_POP: begin
            if (model_tasks.size() == 0) begin
               fresh.push_back(make_result(KIND_REFUSED, '0, 1'b1));
            end else begin
               v = model_tasks.pop_front();
               fresh.push_back(make_result(KIND_POPPED, v, 1'b1));
            end
         end
         REQ_DROP: begin
            if (model_tasks.size() == 0) begin
               fresh.push_back(make_result(KIND_REFUSED, '0, 1'b1));
            end else begin
               n = (model_tasks.size() / 10) * 3;
               if (n == 0) n = 1;
               for (k = 0; k < n; k++) begin
                  // The LFSR steps before each position is taken.
                  lfsr_word = lfsr_word[0] ? ((lfsr_word >> 1) ^ LFSR_TAPS) : (lfsr_word >> 1);
                  pos = int'(lfsr_word % LFSR_W'(model_tasks.size()));
                  v = model_tasks[pos];
                  model_tasks.delete(pos);
                  fresh.push_back(make_result(KIND_DROPPED, v, k == n - 1));
               end
               dropped_handles += n;
               if (n > longest_burst) longest_burst = n;
            end
         end
         default: begin
            fresh.push_back(make_result(KIND_REFUSED, '0, 1'b1));
         end
      endcase
      if (typed) pending_results.push_back(want);
      else foreach (fresh[i]) pending_results.push_back(fresh[i]);
   endfunction

   function automatic void add_check(input logic [1:0] req, input logic [HANDLE_BITS-1:0] handle,
                                     input logic [1:0] kind, input logic [HANDLE_BITS-1:0] out,
                                     input logic [1:0] status, input int occ);
      plan_row_type row;
      row.op             = ROW_ITEM;
      row.req            = req;
      row.data           = LFSR_W'(handle);
      row.typed          = 1'b1;
      row.want.kind      = kind;
      row.want.handle    = out;
      row.want.status    = status;
      row.want.occupancy = COUNT_W'(occ);
      row.want.last      = 1'b1;
      plan.push_back(row);
   endfunction

   function automatic void add_open(input logic [1:0] req, input logic [HANDLE_BITS-1:0] handle);
      plan_row_type row;
      row       = '0;
      row.op    = ROW_ITEM;
      row.req   = req;
      row.data  = LFSR_W'(handle);
      plan.push_back(row);
   endfunction

   function automatic void add_csr(input plan_op_type op, input logic [LFSR_W-1:0] data);
      plan_row_type row;
      row      = '0;
      row.op   = op;
      row.data = data;
      plan.push_back(row);
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0: return 7'd1;
         1: return 7'd2;
         2: return 7'd64;
         3: return 7'd10;
         4: return 7'd30;
         5: return LIMIT_W'($urandom_range(1, 64));
         6: return 7'd0;
         default: return LIMIT_W'($urandom_range(65, 127));
      endcase
   endfunction

   function automatic logic [LFSR_W-1:0] pick_seed();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Start is left high after acceptance; the next item either keeps it high
   // or lowers it for a gap, so it is written only once per edge.
   task automatic send_item(input logic [1:0] req, input logic [HANDLE_BITS-1:0] handle,
                            input logic typed, input result_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= req;
      req_task_handle <= handle;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      apply_request(req, handle, typed, want);
      items_sent++;
   endtask

   task automatic send_open(input logic [1:0] req, input logic [HANDLE_BITS-1:0] handle);
      send_item(req, handle, 1'b0, '0);
   endtask

   task automatic push_or_noise();
      if ($urandom_range(0, 9) == 0) send_open(2'($urandom_range(0, 3)), 16'($urandom()));
      else send_open(REQ_PUSH, 16'($urandom()));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [LFSR_W-1:0] data);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_LIMIT) limit_reg = data[LIMIT_W-1:0];
      else lfsr_word = (data == 0) ? 32'd1 : data;
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result kind", rsp_result_kind, 0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_result_kind !== oldest.kind)
               report_mismatch("result kind", rsp_result_kind, oldest.kind);
            if (rsp_task_out !== oldest.handle)
               report_mismatch("task handle", rsp_task_out, oldest.handle);
            if (rsp_queue_status !== oldest.status)
               report_mismatch("queue status", rsp_queue_status, oldest.status);
            if (rsp_occupancy !== oldest.occupancy)
               report_mismatch("occupancy", rsp_occupancy, oldest.occupancy);
            if (rsp_last !== oldest.last)
               report_mismatch("last flag", rsp_last, oldest.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no item or result for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int          stop_at;
      int          target;
      int          tries;
      int          r;
      logic [31:0] data;

      // Directed part: refusals, extremes of the handle and of the limit,
      // the unused code and a limit lowered below the occupancy.
      add_check(REQ_POP,    16'h0000, KIND_REFUSED, 16'h0000, STAT_EMPTY, 0);
      add_check(REQ_DROP,   16'h0000, KIND_REFUSED, 16'h0000, STAT_EMPTY, 0);
      add_check(REQ_UNUSED, 16'hA5A5, KIND_REFUSED, 16'h0000, STAT_EMPTY, 0);
      add_check(REQ_PUSH,   16'hFFFF, KIND_PUSHED,  16'h0000, STAT_OK,    1);
      add_check(REQ_PUSH,   16'h0000, KIND_PUSHED,  16'h0000, STAT_OK,    2);
      add_check(REQ_POP,    16'h0000, KIND_POPPED,  16'hFFFF, STAT_OK,    1);
      add_check(REQ_DROP,   16'h0000, KIND_DROPPED, 16'h0000, STAT_EMPTY, 0);
      add_csr(ROW_LIMIT, 32'd1);
      add_check(REQ_PUSH,   16'h1234, KIND_PUSHED,  16'h0000, STAT_FULL,  1);
      add_check(REQ_PUSH,   16'h4321, KIND_REFUSED, 16'h0000, STAT_FULL,  1);
      add_check(REQ_UNUSED, 16'hFFFF, KIND_REFUSED, 16'h0000, STAT_FULL,  1);
      add_check(REQ_POP,    16'h0000, KIND_POPPED,  16'h1234, STAT_EMPTY, 0);
      add_csr(ROW_LIMIT, 32'd0);
      add_check(REQ_PUSH,   16'h00FF, KIND_PUSHED,  16'h0000, STAT_FULL,  1);
      add_csr(ROW_LIMIT, 32'd127);
      add_csr(ROW_SEED, 32'd0);
      add_open(REQ_PUSH, 16'h5A5A);
      add_open(REQ_PUSH, 16'hC3C3);
      add_open(REQ_PUSH, 16'h0001);
      add_csr(ROW_LIMIT, 32'd2);
      add_check(REQ_PUSH,   16'h7777, KIND_REFUSED, 16'h0000, STAT_FULL,  4);
      add_open(REQ_POP, 16'h0000);
      add_open(REQ_DROP, 16'h0000);
      add_open(REQ_POP, 16'h0000);
      add_csr(ROW_LIMIT, 32'd64);
      add_open(REQ_POP, 16'h0000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         case (plan[i].op)
            ROW_ITEM:  send_item(plan[i].req, plan[i].data[HANDLE_BITS-1:0],
                                 plan[i].typed, plan[i].want);
            ROW_LIMIT: write_reg(CSR_LIMIT, plan[i].data);
            default:   write_reg(CSR_SEED, plan[i].data);
         endcase
      end
      stop_at = items_sent + RANDOM_ITEMS;

      // First random phase fills the queue to the top so that a drop
      // removes the most entries at once.
      write_reg(CSR_LIMIT, 32'd64);
      write_reg(CSR_SEED, $urandom() | 32'd1);
      while (model_tasks.size() < DEPTH) send_open(REQ_PUSH, 16'($urandom()));
      send_open(REQ_PUSH, 16'($urandom()));
      send_open(REQ_PUSH, 16'($urandom()));
      send_open(REQ_DROP, 16'($urandom()));
      send_open(REQ_DROP, 16'($urandom()));
      send_open(REQ_POP, 16'($urandom()));

      while (items_sent < stop_at) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         data = $urandom();
         if ($urandom_range(0, 3) != 0) data = '0;
         data[LIMIT_W-1:0] = pick_limit();
         write_reg(CSR_LIMIT, data);
         if ($urandom_range(0, 1) == 1) write_reg(CSR_SEED, pick_seed());
         repeat ($urandom_range(1, 3)) begin
            if (items_sent >= stop_at) break;
            target = $urandom_range(0, 24);
            if (target > effective_limit() + 1) target = effective_limit() + 1;
            tries = 0;
            while (model_tasks.size() < target && tries < target + 4 &&
                   items_sent < stop_at) begin
               push_or_noise();
               tries++;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
               send_open(REQ_DROP, 16'($urandom()));
            end else if (r < 85) begin
               repeat ($urandom_range(1, 3)) send_open(REQ_POP, 16'($urandom()));
            end else begin
               repeat ($urandom_range(1, 4))
                  send_open(2'($urandom_range(0, 3)), 16'($urandom()));
            end
            if ($urandom_range(0, 4) == 0) drain_results();
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      $display("Sent %0d items and checked %0d results, %0d of them dropped handles.",
               items_sent, results_seen, dropped_handles);
      $display("Largest drop removed %0d entries; registers were rewritten %0d times.",
               longest_burst, csr_writes);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
